@@ rtl/kes_pkg.sv @@
// ----------------------------------------------------------------------------
// kes_pkg: shared types and constants of the KMC event selector
// Holds the configuration codes, the result codes and the record that moves
// through every pipeline stage.
// ----------------------------------------------------------------------------
package kes_pkg;

   localparam int SquareRounds = 32;   // log2 fraction bits, one per stage
   localparam int PartBits     = 16;   // particle quotient bits
   localparam int TimeBits     = 57;   // time step quotient bits
   localparam int FrontStages  = 5;
   localparam int MidStages    = 34;
   localparam int KindStage    = 16;   // first mid stage after the particle divide
   localparam int LogSubStage  = 32;
   localparam int LogSumStage  = 33;

   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   localparam logic [2:0] CSR_RATE_SUM_FIRST     = 3'd0;
   localparam logic [2:0] CSR_RATE_SUM_SECOND    = 3'd1;
   localparam logic [2:0] CSR_DESORB_RATE_FIRST  = 3'd2;
   localparam logic [2:0] CSR_DIFFUSE_RATE_FIRST = 3'd3;
   localparam logic [2:0] CSR_DESORB_RATE_SECOND = 3'd4;
   localparam logic [2:0] CSR_JUMP_KINDS_FIRST   = 3'd5;
   localparam logic [2:0] CSR_JUMP_KINDS_SECOND  = 3'd6;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_ZERO_RATE = 2'd1;
   localparam logic [1:0] STATUS_NO_JUMP   = 2'd2;

   localparam logic [1:0] KIND_DESORB  = 2'd0;
   localparam logic [1:0] KIND_DIFFUSE = 2'd1;
   localparam logic [1:0] KIND_NONE    = 2'd2;

   typedef struct packed {
      logic [31:0] rate_sum_first;
      logic [31:0] rate_sum_second;
      logic [31:0] desorb_rate_first;
      logic [31:0] diffuse_rate_first;
      logic [31:0] desorb_rate_second;
      logic [1:0]  jump_kinds_first;
      logic        jump_kinds_second;
   } cfg_type;

   typedef struct packed {
      logic [31:0] pf;
      logic [31:0] tf;
      logic [47:0] w0;
      logic [47:0] w1;
      logic [48:0] total;
      logic [48:0] prod_hi;
      logic [63:0] prod_lo;
      logic [48:0] p;
      logic        sp;
      logic [47:0] r;
      logic [31:0] rs;
      logic [31:0] d0;
      logic [31:0] d1;
      logic [1:0]  kinds;
      logic [31:0] prem;
      logic [15:0] pquot;
      logic [4:0]  e;
      logic [31:0] y;
      logic [31:0] f;
      logic [37:0] lna;
      logic [63:0] lnb;
      logic [36:0] ln;
      logic [48:0] trem;
      logic [56:0] tquot;
      logic [1:0]  status;
      logic [1:0]  kind;
   } item_type;

endpackage

@@ rtl/kmc_event_selector_unit.sv @@
// ----------------------------------------------------------------------------
// kmc_event_selector_unit: two-species n-fold way KMC event selection
// Picks species, particle and jump kind from a random fraction and returns
// the time step -ln(u)/R for each transfer on the request channel.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------
//   req     | in        | req_valid / req_ready | fractions and particle counts
//   rsp     | out       | rsp_valid / rsp_ready | status, pick and time step
//   csr     | in        | csr_valid / csr_ready | register index and data
//
// The pipeline has 96 stages (5 front, 34 divide and log, 57 time divide);
// the 57-bit quotient of the time divider, one bit per stage, sets most of
// that depth. One request is taken every cycle while the pipeline is not
// held. All stages hold when the last stage has a result that the consumer
// does not take, so req_ready drops only then.
// Reset clears the valid bits and loads the register reset values; csr
// writes are always taken.
module kmc_event_selector_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_pick_fraction,
   input  logic [31:0] req_time_fraction,
   input  logic [15:0] req_count_first,
   input  logic [15:0] req_count_second,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_species,
   output logic [15:0] rsp_particle,
   output logic [1:0]  rsp_jump_kind,
   output logic [56:0] rsp_time_step,
   output logic [48:0] rsp_total_rate,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import kes_pkg::*;

   cfg_type  cfg_ff;
   logic     adv;
   logic     front_valid;
   item_type front_item;
   logic     mid_valid;
   item_type mid_item;
   logic     last_valid;
   item_type last_item;

   // Configuration registers, written by the user only while the pipeline is
   // empty (the block does not enforce it); stages read them with no snapshot.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{rate_sum_first: '0, rate_sum_second: '0, desorb_rate_first: '0,
                     diffuse_rate_first: '0, desorb_rate_second: '0,
                     jump_kinds_first: 2'd2, jump_kinds_second: 1'b1};
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RATE_SUM_FIRST:     cfg_ff.rate_sum_first     <= csr_wdata;
            CSR_RATE_SUM_SECOND:    cfg_ff.rate_sum_second    <= csr_wdata;
            CSR_DESORB_RATE_FIRST:  cfg_ff.desorb_rate_first  <= csr_wdata;
            CSR_DIFFUSE_RATE_FIRST: cfg_ff.diffuse_rate_first <= csr_wdata;
            CSR_DESORB_RATE_SECOND: cfg_ff.desorb_rate_second <= csr_wdata;
            CSR_JUMP_KINDS_FIRST:   cfg_ff.jump_kinds_first   <= csr_wdata[1:0];
            CSR_JUMP_KINDS_SECOND:  cfg_ff.jump_kinds_second  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // The whole pipeline moves as one unless the final result is stalled.
   assign adv       = !(last_valid && !rsp_ready);
   assign req_ready = adv;

   kes_front u_front (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .cfg           (cfg_ff),
      .in_valid      (req_valid),
      .pick_fraction (req_pick_fraction),
      .time_fraction (req_time_fraction),
      .count_first   (req_count_first),
      .count_second  (req_count_second),
      .out_valid     (front_valid),
      .out_item      (front_item)
   );

   kes_mid u_mid (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (front_valid),
      .in_item   (front_item),
      .out_valid (mid_valid),
      .out_item  (mid_item)
   );

   kes_tdiv u_tdiv (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (mid_valid),
      .in_item   (mid_item),
      .out_valid (last_valid),
      .out_item  (last_item)
   );

   // Result formatting. A zero total rate reports STATUS_ZERO_RATE and clears
   // every other field; an unmatched jump kind keeps the pick but reports no time step.
   assign rsp_valid = last_valid;

   always_comb begin
      if (last_item.total == '0) begin
         rsp_status     = STATUS_ZERO_RATE;
         rsp_species    = 1'b0;
         rsp_particle   = '0;
         rsp_jump_kind  = KIND_DESORB;
         rsp_time_step  = '0;
         rsp_total_rate = '0;
      end else begin
         rsp_status     = last_item.status;
         rsp_species    = last_item.sp;
         rsp_particle   = last_item.pquot;
         rsp_jump_kind  = last_item.kind;
         rsp_time_step  = (last_item.status == STATUS_OK) ? last_item.tquot : '0;
         rsp_total_rate = last_item.total;
      end
   end

endmodule

@@ rtl/kes_front.sv @@
// ----------------------------------------------------------------------------
// kes_front: weights, total rate, pick point and species choice
// Five stages: weights, total and normalize, pick products, pick sum,
// species select.
// ----------------------------------------------------------------------------
module kes_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  kes_pkg::cfg_type  cfg,
   input  logic              in_valid,
   input  logic [31:0]       pick_fraction,
   input  logic [31:0]       time_fraction,
   input  logic [15:0]       count_first,
   input  logic [15:0]       count_second,
   output logic              out_valid,
   output kes_pkg::item_type out_item
);
   import kes_pkg::*;

   item_type stage_ff [0:FrontStages-1];
   item_type stage_in [0:FrontStages-1];
   logic [FrontStages-1:0] vld_ff;

   always_comb begin
      stage_in[0] = '0;
      stage_in[0].pf = pick_fraction;
      stage_in[0].tf = (time_fraction == 32'd0) ? 32'd1 : time_fraction;
      stage_in[0].w0 = cfg.rate_sum_first * count_first;
      stage_in[0].w1 = cfg.rate_sum_second * count_second;
   end

   always_comb begin
      stage_in[1] = stage_ff[0];
      stage_in[1].total = {1'b0, stage_ff[0].w0} + {1'b0, stage_ff[0].w1};
      stage_in[1].e = '0;
      for (int i = 0; i < 32; i++) begin
         if (stage_ff[0].tf[i]) stage_in[1].e = 5'(i);
      end
      stage_in[1].y = stage_ff[0].tf << (5'd31 - stage_in[1].e);
   end

   always_comb begin
      stage_in[2] = stage_ff[1];
      stage_in[2].prod_hi = stage_ff[1].total[48:32] * stage_ff[1].pf;
      stage_in[2].prod_lo = stage_ff[1].total[31:0] * stage_ff[1].pf;
   end

   always_comb begin
      stage_in[3] = stage_ff[2];
      stage_in[3].p = stage_ff[2].prod_hi + {17'd0, stage_ff[2].prod_lo[63:32]};
   end

   always_comb begin
      logic [48:0] diff;
      diff = stage_ff[3].p - {1'b0, stage_ff[3].w0};
      stage_in[4] = stage_ff[3];
      stage_in[4].trem  = '0;
      stage_in[4].tquot = '0;
      stage_in[4].pquot = '0;
      if (stage_ff[3].p < {1'b0, stage_ff[3].w0}) begin
         stage_in[4].sp    = 1'b0;
         stage_in[4].r     = stage_ff[3].p[47:0];
         stage_in[4].rs    = cfg.rate_sum_first;
         stage_in[4].d0    = cfg.desorb_rate_first;
         stage_in[4].d1    = cfg.diffuse_rate_first;
         stage_in[4].kinds = (cfg.jump_kinds_first == 2'd3) ? 2'd2 : cfg.jump_kinds_first;
      end else begin
         stage_in[4].sp    = 1'b1;
         stage_in[4].r     = diff[47:0];
         stage_in[4].rs    = cfg.rate_sum_second;
         stage_in[4].d0    = cfg.desorb_rate_second;
         stage_in[4].d1    = '0;
         stage_in[4].kinds = {1'b0, cfg.jump_kinds_second};
      end
      // The quotient fits in 16 bits, so the upper remainder starts below rs.
      stage_in[4].prem = stage_in[4].r[47:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[FrontStages-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < FrontStages; k++) stage_ff[k] <= stage_in[k];
      end
   end

   assign out_valid = vld_ff[FrontStages-1];
   assign out_item  = stage_ff[FrontStages-1];

endmodule

@@ rtl/kes_mid.sv @@
// ----------------------------------------------------------------------------
// kes_mid: particle divide, jump kind pick and -ln(u) evaluation
// One squaring round of the log2 mantissa per stage, one quotient bit of the
// particle index per stage for the first sixteen, then the ln scaling.
// ----------------------------------------------------------------------------
module kes_mid (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  kes_pkg::item_type in_item,
   output logic              out_valid,
   output kes_pkg::item_type out_item
);
   import kes_pkg::*;

   item_type stage_ff [0:MidStages-1];
   item_type stage_in [0:MidStages-1];
   item_type src      [0:MidStages-1];
   logic [MidStages-1:0] vld_ff;

   assign src[0] = in_item;

   for (genvar i = 0; i < MidStages; i++) begin : g_stage
      logic part_bit;

      if (i > 0) begin : g_src
         assign src[i] = stage_ff[i-1];
      end

      // Dividend bit shifted into the particle remainder at this stage.
      if (i < PartBits) begin : g_part
         assign part_bit = src[i].r[PartBits-1-i];
      end else begin : g_nopart
         assign part_bit = 1'b0;
      end

      always_comb begin
         logic [63:0] sq;
         logic [32:0] sh;
         logic [32:0] prem_x;
         logic [32:0] wsum;
         logic [37:0] n;
         stage_in[i] = src[i];
         sq     = '0;
         sh     = '0;
         prem_x = '0;
         wsum   = '0;
         n      = '0;
         if (i < SquareRounds) begin
            sq = src[i].y * src[i].y;
            sh = sq[63:31];
            if (sh[32]) begin
               stage_in[i].y = sh[32:1];
               stage_in[i].f = {src[i].f[30:0], 1'b1};
            end else begin
               stage_in[i].y = sh[31:0];
               stage_in[i].f = {src[i].f[30:0], 1'b0};
            end
         end
         if (i < PartBits) begin
            prem_x = {src[i].prem, part_bit};
            if (prem_x >= {1'b0, src[i].rs}) begin
               prem_x = prem_x - {1'b0, src[i].rs};
               stage_in[i].pquot = {src[i].pquot[14:0], 1'b1};
            end else begin
               stage_in[i].pquot = {src[i].pquot[14:0], 1'b0};
            end
            stage_in[i].prem = prem_x[31:0];
         end
         if (i == KindStage) begin
            wsum = {1'b0, src[i].d0} + {1'b0, src[i].d1};
            stage_in[i].kind   = KIND_NONE;
            stage_in[i].status = STATUS_NO_JUMP;
            if (src[i].kinds != 2'd0 && src[i].prem < src[i].d0) begin
               stage_in[i].kind   = KIND_DESORB;
               stage_in[i].status = STATUS_OK;
            end else if (src[i].kinds == 2'd2 && {1'b0, src[i].prem} < wsum) begin
               stage_in[i].kind   = KIND_DIFFUSE;
               stage_in[i].status = STATUS_OK;
            end
         end
         if (i == LogSubStage) begin
            n = {6'd32, 32'd0} - ({1'b0, src[i].e, 32'd0} + {6'd0, src[i].f});
            stage_in[i].lna = n[37:32] * LN2_Q32;
            stage_in[i].lnb = n[31:0] * LN2_Q32;
         end
         if (i == LogSumStage) begin
            n = src[i].lna + {6'd0, src[i].lnb[63:32]};
            stage_in[i].ln = n[36:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[MidStages-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < MidStages; k++) stage_ff[k] <= stage_in[k];
      end
   end

   assign out_valid = vld_ff[MidStages-1];
   assign out_item  = stage_ff[MidStages-1];

endmodule

@@ rtl/kes_tdiv.sv @@
// ----------------------------------------------------------------------------
// kes_tdiv: time step divider
// Restoring division of ln(1/u) * 2^20 by the total rate, one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module kes_tdiv (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  kes_pkg::item_type in_item,
   output logic              out_valid,
   output kes_pkg::item_type out_item
);
   import kes_pkg::*;

   item_type stage_ff [0:TimeBits-1];
   item_type stage_in [0:TimeBits-1];
   item_type src      [0:TimeBits-1];
   logic [TimeBits-1:0] vld_ff;

   assign src[0] = in_item;

   for (genvar j = 0; j < TimeBits; j++) begin : g_stage
      if (j > 0) begin : g_src
         assign src[j] = stage_ff[j-1];
      end

      always_comb begin
         logic [56:0] dvd;
         logic [49:0] rem;
         dvd = {src[j].ln, 20'd0};
         rem = {src[j].trem, dvd[TimeBits-1-j]};
         stage_in[j] = src[j];
         if (rem >= {1'b0, src[j].total}) begin
            rem = rem - {1'b0, src[j].total};
            stage_in[j].tquot = {src[j].tquot[55:0], 1'b1};
         end else begin
            stage_in[j].tquot = {src[j].tquot[55:0], 1'b0};
         end
         stage_in[j].trem = rem[48:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[TimeBits-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < TimeBits; k++) stage_ff[k] <= stage_in[k];
      end
   end

   assign out_valid = vld_ff[TimeBits-1];
   assign out_item  = stage_ff[TimeBits-1];

endmodule

@@ verif/kmc_event_selector_unit_checker.sv @@
// ----------------------------------------------------------------------------
// kmc_event_selector_unit_checker: result checker of the KMC event selector
// Follows register writes and request transfers, predicts the event pick and
// time step of every request and compares each response transfer in order.
// ----------------------------------------------------------------------------
module kmc_event_selector_unit_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_pick_fraction,
   input  logic [31:0] req_time_fraction,
   input  logic [15:0] req_count_first,
   input  logic [15:0] req_count_second,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic        rsp_species,
   input  logic [15:0] rsp_particle,
   input  logic [1:0]  rsp_jump_kind,
   input  logic [56:0] rsp_time_step,
   input  logic [48:0] rsp_total_rate,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   import kes_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] Mask32 = 64'hFFFF_FFFF;

   typedef struct {
      logic [1:0]  status;
      logic        species;
      logic [15:0] particle;
      logic [1:0]  jump_kind;
      logic [56:0] time_step;
      logic [48:0] total_rate;
   } pick_type;

   cfg_type  rates;
   pick_type pick_queue[$];

   // Elapsed-time numerator -ln(t / 2^32) in Q.32, t nonzero.
   function automatic logic [63:0] neg_log_q32(logic [31:0] t);
      int          top;
      logic [63:0] y, f, n, whole, frac;
      top = 0;
      for (int i = 0; i < 32; i++)
         if (t[i]) top = i;
      y = ({32'd0, t} << (31 - top)) & Mask32;
      f = 0;
      for (int i = 0; i < SquareRounds; i++) begin
         y = (y * y) >> 31;
         f = f << 1;
         if (y >= 64'h1_0000_0000) begin
            y = y >> 1;
            f = f | 64'd1;
         end
      end
      n = (64'd32 << 32) - ((64'(top) << 32) + f);
      whole = n >> 32;
      frac = n & Mask32;
      return whole * LN2_Q32 + ((frac * LN2_Q32) >> 32);
   endfunction

   function automatic pick_type predict_pick(logic [31:0] pf, logic [31:0] tf,
                                             logic [15:0] c0, logic [15:0] c1);
      pick_type    res;
      logic [63:0] w0, w1, total, p, r, rs, part, w, sum, kinds;
      logic [63:0] kind_rate [2];
      logic [31:0] tfx;
      res = '{STATUS_ZERO_RATE, 1'b0, 16'd0, 2'd0, 57'd0, 49'd0};
      w0 = 64'(rates.rate_sum_first) * c0;
      w1 = 64'(rates.rate_sum_second) * c1;
      total = (w0 + w1) & ((64'd1 << 49) - 1);
      if (total == 0) return res;
      p = (total >> 32) * pf + (((total & Mask32) * pf) >> 32);
      if (p < w0) begin
         res.species = 1'b0;
         r = p;
         rs = rates.rate_sum_first;
         kind_rate[0] = rates.desorb_rate_first;
         kind_rate[1] = rates.diffuse_rate_first;
         kinds = (rates.jump_kinds_first > 2) ? 2 : rates.jump_kinds_first;
      end else begin
         res.species = 1'b1;
         r = p - w0;
         rs = rates.rate_sum_second;
         kind_rate[0] = rates.desorb_rate_second;
         kind_rate[1] = 0;
         kinds = rates.jump_kinds_second;
      end
      part = (rs != 0) ? r / rs : 0;
      w = r - part * rs;
      res.status = STATUS_NO_JUMP;
      res.jump_kind = KIND_NONE;
      sum = 0;
      for (int k = 0; k < kinds; k++) begin
         sum += kind_rate[k];
         if (w < sum) begin
            res.jump_kind = 2'(k);
            res.status = STATUS_OK;
            break;
         end
      end
      if (res.status == STATUS_OK) begin
         tfx = (tf == 0) ? 32'd1 : tf;
         res.time_step = 57'((neg_log_q32(tfx) << 20) / total);
      end
      res.particle = part[15:0];
      res.total_rate = total[48:0];
      return res;
   endfunction

   assign pending = pick_queue.size();

   always @(posedge clock) begin
      pick_type want;
      if (reset) begin
         rates <= '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 2'd2, 1'b1};
         pick_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RATE_SUM_FIRST:     rates.rate_sum_first <= csr_wdata;
               CSR_RATE_SUM_SECOND:    rates.rate_sum_second <= csr_wdata;
               CSR_DESORB_RATE_FIRST:  rates.desorb_rate_first <= csr_wdata;
               CSR_DIFFUSE_RATE_FIRST: rates.diffuse_rate_first <= csr_wdata;
               CSR_DESORB_RATE_SECOND: rates.desorb_rate_second <= csr_wdata;
               CSR_JUMP_KINDS_FIRST:   rates.jump_kinds_first <= csr_wdata[1:0];
               CSR_JUMP_KINDS_SECOND:  rates.jump_kinds_second <= csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            pick_queue.push_back(predict_pick(req_pick_fraction, req_time_fraction,
                                              req_count_first, req_count_second));
         if (rsp_valid && rsp_ready) begin
            if (pick_queue.size() == 0) begin
               $display("%0t: response transfer with no request waiting", $time);
               fail_count <= fail_count + 1;
            end else begin
               want = pick_queue.pop_front();
               if (want.status !== rsp_status || want.species !== rsp_species
                   || want.particle !== rsp_particle
                   || want.jump_kind !== rsp_jump_kind
                   || want.time_step !== rsp_time_step
                   || want.total_rate !== rsp_total_rate) begin
                  $display("%0t: mismatch expected st=%0d sp=%0d pt=%0d jk=%0d dt=%0d tot=%0d",
                           $time, want.status, want.species, want.particle,
                           want.jump_kind, want.time_step, want.total_rate);
                  $display("%0t:          actual   st=%0d sp=%0d pt=%0d jk=%0d dt=%0d tot=%0d",
                           $time, rsp_status, rsp_species, rsp_particle,
                           rsp_jump_kind, rsp_time_step, rsp_total_rate);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

@@ verif/kmc_event_selector_unit_test.sv @@
// ----------------------------------------------------------------------------
// kmc_event_selector_unit_test: regression of the KMC event selector
// Writes several register settings, sends directed and random event draws
// with random idling on both channels and lets the checker compare results.
// ----------------------------------------------------------------------------
module kmc_event_selector_unit_test;
   import kes_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Index beyond the register list; the block must ignore writes to it.
   localparam logic [2:0] CsrSpare = 3'd7;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid, req_ready;
   logic [31:0] req_pick_fraction, req_time_fraction;
   logic [15:0] req_count_first, req_count_second;
   logic        rsp_valid, rsp_ready;
   logic [1:0]  rsp_status, rsp_jump_kind;
   logic        rsp_species;
   logic [15:0] rsp_particle;
   logic [56:0] rsp_time_step;
   logic [48:0] rsp_total_rate;
   logic        csr_valid, csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;
   int          fail_count, pending;
   bit          quiet = 1'b0;   // set in the last part of the run: no idling
   int          rsp_hold = 0;

   always #5 clock = ~clock;

   kmc_event_selector_unit dut (.*);

   kmc_event_selector_unit_checker checker_inst (.*);

   // The consumer stalls in random bursts until the quiet part of the run.
   always @(posedge clock) begin
      if (quiet) begin
         rsp_ready <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_hold <= $urandom_range(0, 12);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // One register write; the valid drops once the transfer has happened and
   // the channel rests before the next write.
   task automatic write_reg(logic [2:0] index, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Presents one event draw and returns at the edge of its transfer or after
   // a random idle with valid low; else valid stays high into the next draw.
   task automatic send_draw(logic [31:0] pf, logic [31:0] tf,
                            logic [15:0] c0, logic [15:0] c1);
      req_valid <= 1'b1;
      req_pick_fraction <= pf;
      req_time_fraction <= tf;
      req_count_first <= c0;
      req_count_second <= c1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // Registers may only change while nothing is in flight.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Rates are drawn across their extremes: zero, full scale, small values
   // that make the jump search miss, and fully random words.
   function automatic logic [31:0] pick_rate();
      case ($urandom_range(0, 4))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(1, 8192);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick_count();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return $urandom_range(1, 4);
         default: return $urandom;
      endcase
   endfunction

   task automatic write_all(logic [31:0] rs0, logic [31:0] rs1, logic [31:0] d0,
                            logic [31:0] f0, logic [31:0] d1, logic [1:0] k0,
                            logic k1);
      write_reg(CSR_RATE_SUM_FIRST, rs0);
      write_reg(CSR_RATE_SUM_SECOND, rs1);
      write_reg(CSR_DESORB_RATE_FIRST, d0);
      write_reg(CSR_DIFFUSE_RATE_FIRST, f0);
      write_reg(CSR_DESORB_RATE_SECOND, d1);
      write_reg(CSR_JUMP_KINDS_FIRST, {30'd0, k0});
      write_reg(CSR_JUMP_KINDS_SECOND, {31'd0, k1});
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_pick_fraction <= '0;
      req_time_fraction <= '0;
      req_count_first <= '0;
      req_count_second <= '0;
      rsp_ready <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values give a zero total rate whatever the counts are.
      send_draw(32'h8000_0000, 32'h1234_5678, 16'hFFFF, 16'hFFFF);
      drain();

      // Balanced species; extremes of the fractions and the counts, a zero
      // time fraction, and a species with no particles that must never win.
      write_all(32'h0000_1000, 32'h0000_2000, 32'h0000_0800, 32'h0000_0800,
                32'h0000_2000, 2'd2, 1'b1);
      send_draw(32'h0000_0000, 32'h0000_0000, 16'd1, 16'd1);
      send_draw(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1, 16'd1);
      send_draw(32'h7FFF_FFFF, 32'h0000_0001, 16'hFFFF, 16'hFFFF);
      send_draw(32'hFFFF_FFFF, 32'h8000_0000, 16'd0, 16'd5);
      send_draw(32'h0000_0000, 32'h0000_0002, 16'd5, 16'd0);
      send_draw(32'hC000_0000, 32'hDEAD_BEEF, 16'd3, 16'd3);
      send_draw(32'h4000_0000, 32'h0000_0000, 16'd0, 16'd0);
      drain();

      // Three jump kinds for species 0 behave as two; writes to the spare
      // index must change nothing.
      write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd0,
                2'd3, 1'b1);
      write_reg(CsrSpare, 32'hFFFF_FFFF);
      send_draw(32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      send_draw(32'hFFFF_FFFF, 32'h0000_0001, 16'hFFFF, 16'hFFFF);
      send_draw(32'h2000_0000, 32'h0000_0000, 16'hFFFF, 16'd0);
      drain();

      // No jump kinds in use: every pick misses.
      write_all(32'h0000_0010, 32'h0000_0010, 32'd5, 32'd5, 32'd5, 2'd0, 1'b0);
      send_draw(32'h0000_0000, 32'h5555_5555, 16'd7, 16'd7);
      send_draw(32'hFFFF_FFFF, 32'hAAAA_AAAA, 16'd7, 16'd7);
      drain();

      // Random phases, each with its own register setting.
      for (int phase = 0; phase < 7; phase++) begin
         write_all(pick_rate(), pick_rate(), pick_rate(), pick_rate(), pick_rate(),
                   2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
         quiet = (phase == 6);
         for (int i = 0; i < 100; i++)
            send_draw($urandom, $urandom, pick_count(), pick_count());
         drain();
      end

      // Silence past the last response before the verdict.
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("kmc_event_selector_unit regression: pass");
      else
         $display("kmc_event_selector_unit regression: fail");
      $finish;
   end

   initial begin
      #20ms;
      $display("kmc_event_selector_unit regression: fail");
      $finish;
   end

endmodule
